// ===== src/plcfp_pkg.sv =====
// plcfp_pkg: shared types and constants for the plc frame parser
`timescale 1ns / 1ps

package plcfp_pkg;

  localparam logic [4:0]  HDR_LEN    = 5'd20;
  localparam logic [4:0]  TAG_LEN    = 5'd8;
  localparam logic [4:0]  POS_CPU    = 5'd12;
  localparam logic [4:0]  POS_SRC    = 5'd13;
  localparam logic [4:0]  POS_INV_LO = 5'd14;
  localparam logic [4:0]  POS_INV_HI = 5'd15;
  localparam logic [4:0]  POS_LEN_LO = 5'd16;
  localparam logic [4:0]  POS_LEN_HI = 5'd17;
  localparam logic [16:0] CNT_MAX    = 17'h1FFFF;

  localparam logic [15:0] CMD_RD_A   = 16'h0054;
  localparam logic [15:0] CMD_RD_B   = 16'h0055;
  localparam logic [15:0] CMD_WR_A   = 16'h0058;
  localparam logic [15:0] CMD_WR_B   = 16'h0059;
  localparam logic [15:0] DTYPE_CONT = 16'h0014;
  localparam logic [7:0]  SRC_RESP   = 8'h11;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR = 3'd1;
  localparam logic [2:0] ST_BAD_TAG   = 3'd2;
  localparam logic [2:0] ST_BAD_CMD   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_CNT_NOT1  = 3'd5;
  localparam logic [2:0] ST_TRAILING  = 3'd6;

  typedef enum logic [3:0] {
    PH_HDR, PH_CMD, PH_DTYPE, PH_RSV, PH_ERRST, PH_ERRINFO, PH_CDSIZE,
    PH_BLKLEN, PH_REQCNT, PH_VARLEN, PH_REQDSIZE, PH_WRLEN, PH_SKIP,
    PH_DONE, PH_ERR
  } phase_e;

  typedef enum logic [2:0] {
    RET_DONE, RET_RBLK, RET_CVAR, RET_VAR, RET_WR
  } ret_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  source_code;
    logic [15:0] invoke_id;
    logic [15:0] declared_length;
    logic        length_mismatch;
    logic [7:0]  cpu_info;
    logic [15:0] command;
    logic [15:0] data_type;
    logic [15:0] block_count;
    logic [15:0] error_status;
    logic [15:0] error_info;
    logic [15:0] data_size;
  } res_t;

  function automatic logic [7:0] tag_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h4C;
      3'd1: b = 8'h53;
      3'd2: b = 8'h49;
      3'd3: b = 8'h53;
      3'd4: b = 8'h2D;
      3'd5: b = 8'h58;
      3'd6: b = 8'h47;
      3'd7: b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/plcfp_core.sv =====
// plcfp_core: header check and body walk state, summary result per frame
`timescale 1ns / 1ps

module plcfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output plcfp_pkg::res_t   res_o
);
  import plcfp_pkg::*;

  logic [4:0]  hpos_q, hpos_d;
  phase_e      phase_q, phase_d;
  logic [16:0] off_q, off_d;
  logic [15:0] skip_q, skip_d;
  ret_e        ret_q, ret_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  low_q, low_d;
  logic        have_low_q, have_low_d;
  logic        tag_ok_q, tag_ok_d;
  logic [2:0]  err_q, err_d;
  logic [7:0]  cpu_q, cpu_d, src_q, src_d;
  logic [15:0] inv_q, inv_d, len_q, len_d;
  logic [15:0] cmd_q, cmd_d, dtype_q, dtype_d, blk_q, blk_d;
  logic [15:0] errst_q, errst_d, errinfo_q, errinfo_d, dsize_q, dsize_d;

  logic        is_rd, is_wr, is_cont;
  logic [15:0] word;
  logic        do_skip, do_fin;
  logic [15:0] skip_len;
  ret_e        skip_ret, fin_ret;
  logic [16:0] blk_inc;
  logic        more_blk;
  logic [2:0]  status;

  assign is_rd    = (cmd_q == CMD_RD_A) || (cmd_q == CMD_RD_B);
  assign is_wr    = (cmd_q == CMD_WR_A) || (cmd_q == CMD_WR_B);
  assign is_cont  = (dtype_q == DTYPE_CONT);
  assign word     = {byte_i, low_q};
  assign blk_inc  = {1'b0, idx_q} + 17'd1;
  assign more_blk = blk_inc < {1'b0, blk_q};

  always_comb begin
    hpos_d = hpos_q;   phase_d = phase_q;   off_d = off_q;     skip_d = skip_q;
    ret_d = ret_q;     idx_d = idx_q;       low_d = low_q;     have_low_d = have_low_q;
    tag_ok_d = tag_ok_q; err_d = err_q;     cpu_d = cpu_q;     src_d = src_q;
    inv_d = inv_q;     len_d = len_q;       cmd_d = cmd_q;     dtype_d = dtype_q;
    blk_d = blk_q;     errst_d = errst_q;   errinfo_d = errinfo_q; dsize_d = dsize_q;
    do_skip = 1'b0;    skip_len = '0;       skip_ret = RET_DONE;
    do_fin = 1'b0;     fin_ret = RET_DONE;
    res_o = '0;

    if (en_i) begin
      if (hpos_q < HDR_LEN) begin
        // header bytes
        if (hpos_q < TAG_LEN && byte_i != tag_byte(hpos_q[2:0])) begin
          tag_ok_d = 1'b0;
        end
        if (hpos_q == POS_CPU)    cpu_d = byte_i;
        if (hpos_q == POS_SRC)    src_d = byte_i;
        if (hpos_q == POS_INV_LO) inv_d[7:0] = byte_i;
        if (hpos_q == POS_INV_HI) inv_d[15:8] = byte_i;
        if (hpos_q == POS_LEN_LO) len_d[7:0] = byte_i;
        if (hpos_q == POS_LEN_HI) len_d[15:8] = byte_i;
        hpos_d = hpos_q + 5'd1;
        if (hpos_d == HDR_LEN) begin
          if (!tag_ok_d) begin
            err_d   = ST_BAD_TAG;
            phase_d = PH_ERR;
          end else begin
            phase_d = PH_CMD;
          end
        end
      end else begin
        // body bytes inside the declared region
        if (off_q < {1'b0, len_q}) begin
          case (phase_q)
            PH_ERR: begin
            end
            PH_DONE: begin
              err_d   = ST_TRAILING;
              phase_d = PH_ERR;
            end
            PH_SKIP: begin
              skip_d = skip_q - 16'd1;
              if (skip_q == 16'd1) begin
                do_fin  = 1'b1;
                fin_ret = ret_q;
              end
            end
            default: begin
              if (!have_low_q) begin
                low_d      = byte_i;
                have_low_d = 1'b1;
              end else begin
                have_low_d = 1'b0;
                case (phase_q)
                  PH_CMD: begin
                    cmd_d   = word;
                    phase_d = PH_DTYPE;
                  end
                  PH_DTYPE: begin
                    dtype_d = word;
                    if (is_rd || is_wr) begin
                      phase_d = PH_RSV;
                    end else begin
                      err_d   = ST_BAD_CMD;
                      phase_d = PH_ERR;
                    end
                  end
                  PH_RSV: begin
                    phase_d = (src_q == SRC_RESP) ? PH_ERRST : PH_REQCNT;
                  end
                  PH_ERRST: begin
                    errst_d = word;
                    phase_d = PH_ERRINFO;
                  end
                  PH_ERRINFO: begin
                    errinfo_d = word;
                    if (errst_q != 16'd0) begin
                      phase_d = PH_DONE;
                    end else if (is_cont) begin
                      phase_d = PH_CDSIZE;
                    end else begin
                      blk_d   = word;
                      idx_d   = '0;
                      phase_d = (word == 16'd0) ? PH_DONE : PH_BLKLEN;
                    end
                  end
                  PH_CDSIZE: begin
                    dsize_d  = word;
                    do_skip  = 1'b1;
                    skip_len = word;
                    skip_ret = RET_DONE;
                  end
                  PH_BLKLEN: begin
                    do_skip  = 1'b1;
                    skip_len = word;
                    skip_ret = RET_RBLK;
                  end
                  PH_REQCNT: begin
                    blk_d = word;
                    idx_d = '0;
                    if (is_cont) begin
                      if (word != 16'd1) begin
                        err_d   = ST_CNT_NOT1;
                        phase_d = PH_ERR;
                      end else begin
                        phase_d = PH_VARLEN;
                      end
                    end else begin
                      phase_d = (word == 16'd0) ? PH_DONE : PH_VARLEN;
                    end
                  end
                  PH_VARLEN: begin
                    do_skip  = 1'b1;
                    skip_len = word;
                    skip_ret = is_cont ? RET_CVAR : RET_VAR;
                  end
                  PH_REQDSIZE: begin
                    dsize_d = word;
                    if (is_rd) begin
                      phase_d = PH_DONE;
                    end else begin
                      do_skip  = 1'b1;
                      skip_len = word;
                      skip_ret = RET_DONE;
                    end
                  end
                  PH_WRLEN: begin
                    do_skip  = 1'b1;
                    skip_len = word;
                    skip_ret = RET_WR;
                  end
                  default: begin
                  end
                endcase
              end
            end
          endcase
        end
        if (off_q != CNT_MAX) begin
          off_d = off_q + 17'd1;
        end
      end
    end

    // start of a length-prefixed skip, zero length finishes at once
    if (do_skip) begin
      skip_d = skip_len;
      ret_d  = skip_ret;
      if (skip_len == 16'd0) begin
        do_fin  = 1'b1;
        fin_ret = skip_ret;
      end else begin
        phase_d = PH_SKIP;
      end
    end

    if (do_fin) begin
      case (fin_ret)
        RET_CVAR: phase_d = PH_REQDSIZE;
        RET_RBLK: begin
          idx_d   = blk_inc[15:0];
          phase_d = more_blk ? PH_BLKLEN : PH_DONE;
        end
        RET_VAR: begin
          idx_d = blk_inc[15:0];
          if (more_blk) begin
            phase_d = PH_VARLEN;
          end else if (is_wr) begin
            idx_d   = '0;
            phase_d = PH_WRLEN;
          end else begin
            phase_d = PH_DONE;
          end
        end
        RET_WR: begin
          idx_d   = blk_inc[15:0];
          phase_d = more_blk ? PH_WRLEN : PH_DONE;
        end
        default: phase_d = PH_DONE;
      endcase
    end

    // summary for the frame
    if (hpos_d < HDR_LEN) begin
      status = ST_SHORT_HDR;
    end else if (phase_d == PH_ERR) begin
      status = err_d;
    end else if (phase_d == PH_DONE) begin
      status = ST_OK;
    end else begin
      status = ST_TRUNC;
    end
    res_o.status = status;
    if (status != ST_SHORT_HDR && status != ST_BAD_TAG) begin
      res_o.source_code     = src_d;
      res_o.invoke_id       = inv_d;
      res_o.declared_length = len_d;
      res_o.length_mismatch = (off_d != {1'b0, len_d});
      res_o.cpu_info        = cpu_d;
    end
    if (status == ST_OK) begin
      res_o.command      = cmd_d;
      res_o.data_type    = dtype_d;
      res_o.block_count  = blk_d;
      res_o.error_status = errst_d;
      res_o.error_info   = errinfo_d;
      res_o.data_size    = dsize_d;
    end

    // fresh state for the next frame
    if (en_i && last_i) begin
      hpos_d = '0;       phase_d = PH_HDR;   off_d = '0;       skip_d = '0;
      ret_d = RET_DONE;  idx_d = '0;         low_d = '0;       have_low_d = 1'b0;
      tag_ok_d = 1'b1;   err_d = '0;         cpu_d = '0;       src_d = '0;
      inv_d = '0;        len_d = '0;         cmd_d = '0;       dtype_d = '0;
      blk_d = '0;        errst_d = '0;       errinfo_d = '0;   dsize_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpos_q <= '0;       phase_q <= PH_HDR;  off_q <= '0;      skip_q <= '0;
      ret_q <= RET_DONE;  idx_q <= '0;        low_q <= '0;      have_low_q <= 1'b0;
      tag_ok_q <= 1'b1;   err_q <= '0;        cpu_q <= '0;      src_q <= '0;
      inv_q <= '0;        len_q <= '0;        cmd_q <= '0;      dtype_q <= '0;
      blk_q <= '0;        errst_q <= '0;      errinfo_q <= '0;  dsize_q <= '0;
    end else begin
      hpos_q <= hpos_d;   phase_q <= phase_d; off_q <= off_d;   skip_q <= skip_d;
      ret_q <= ret_d;     idx_q <= idx_d;     low_q <= low_d;   have_low_q <= have_low_d;
      tag_ok_q <= tag_ok_d; err_q <= err_d;   cpu_q <= cpu_d;   src_q <= src_d;
      inv_q <= inv_d;     len_q <= len_d;     cmd_q <= cmd_d;   dtype_q <= dtype_d;
      blk_q <= blk_d;     errst_q <= errst_d; errinfo_q <= errinfo_d; dsize_q <= dsize_d;
    end
  end

endmodule

// ===== src/plc_frame_parser.sv =====
// plc_frame_parser: stream top level with input and result registers
`timescale 1ns / 1ps

// Takes payload bytes on the slave stream, tlast on the final byte of a frame.
// Each byte goes through an input register and then the header check and body
// walk, so a byte can be accepted every cycle unless a final byte is held back.
// The summary item for a frame follows its final byte through the input and
// result registers; while a summary waits on the master side, ordinary bytes
// keep flowing and only the next final byte is held back.
// Status travels in tuser: 0 ok, 1 short header, 2 bad tag, 3 bad command,
// 4 truncated, 5 continuous count not one, 6 trailing bytes.
module plc_frame_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // source_code, invoke_id, declared_length, length_mismatch, cpu_info,
  // command, data_type, block_count, error_status, error_info, data_size
  output logic [151:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o    // status
);
  import plcfp_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q, out_vld_d;
  res_t       out_res_q;
  res_t       res;
  logic       advance;

  assign advance         = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_vld_d        = s_axis_tready_o ? s_axis_tvalid_i : in_vld_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (advance && in_last_q) begin
      out_vld_d = 1'b1;
    end
  end

  plcfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && in_last_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = {7'd0,
                            out_res_q.data_size,
                            out_res_q.error_info,
                            out_res_q.error_status,
                            out_res_q.block_count,
                            out_res_q.data_type,
                            out_res_q.command,
                            out_res_q.cpu_info,
                            out_res_q.length_mismatch,
                            out_res_q.declared_length,
                            out_res_q.invoke_id,
                            out_res_q.source_code};

endmodule
